FILE: rtl/sha256bsh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Used by sha256bsh_core and sha256_byte_stream_hasher; depends on nothing.
package sha256bsh_pkg;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [7:0] PAD_ZERO   = 8'h00;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control from the sequencer to the compression core
  typedef struct packed {
    logic       shift_en;   // shift one byte into the message window
    logic [7:0] byte_in;
    logic       start;      // load working variables, begin 64 rounds
    logic       reinit;     // restore the initial hash value
  } core_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;             // final add of chaining value this cycle
  } core_stat_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream: an item may carry one byte (byte_valid) and may
// close the message (end_of_message). Bytes are taken one per cycle until a
// 64-byte block is full; the block then holds in_stall high through the 64
// rounds of the single shared round unit and the chaining add. On end of
// message the block inserts padding and the 64-bit bit length byte by byte,
// pausing while a block is compressed, and with the one or two last
// compressions holds in_stall high after the closing transfer (for the
// shortest time when the marker lands just before the length field, the
// longest when padding spills into a second block), then presents the
// digest as eight transfers, word 0 first, with last_word on the eighth.
// After the eighth transfer the hasher is back at its initial state. There
// is no clearing pass after reset. Depends on sha256bsh_pkg and sha256bsh_core.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256bsh_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MARK, S_ZERO, S_LEN, S_COMP, S_OUT} state_t;

  state_t      state;
  state_t      resume;
  logic [5:0]  fill;
  logic [63:0] total;
  logic [2:0]  idx;

  core_ctrl_t  ctrl;
  core_stat_t  core_stat;
  logic [63:0] bit_len;
  logic [63:0] len_shift;

  // length bytes go out most significant first, one per fill position
  assign bit_len   = {total[60:0], 3'b000};
  assign len_shift = bit_len >> {~fill[2:0], 3'b000};

  always_comb begin
    ctrl = '0;
    case (state)
      S_IDLE: begin
        ctrl.shift_en = in_valid && byte_valid;
        ctrl.byte_in  = data_byte;
        ctrl.start    = in_valid && byte_valid && (fill == FILL_LAST);
      end
      S_MARK: begin
        ctrl.shift_en = 1'b1;
        ctrl.byte_in  = PAD_MARK;
        ctrl.start    = (fill == FILL_LAST);
      end
      S_ZERO: begin
        ctrl.shift_en = (fill != LEN_START);
        ctrl.byte_in  = PAD_ZERO;
        ctrl.start    = (fill == FILL_LAST);
      end
      S_LEN: begin
        ctrl.shift_en = 1'b1;
        ctrl.byte_in  = len_shift[7:0];
        ctrl.start    = (fill == FILL_LAST);
      end
      S_OUT: begin
        ctrl.reinit = !out_stall && (idx == WORD_LAST);
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      resume <= S_IDLE;
      fill   <= '0;
      total  <= '0;
      idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (byte_valid) begin
              fill  <= fill + 6'd1;
              total <= total + 64'd1;
            end
            if (ctrl.start) begin
              state  <= S_COMP;
              resume <= end_of_message ? S_MARK : S_IDLE;
            end else if (end_of_message) begin
              state <= S_MARK;
            end
          end
        end
        S_MARK: begin
          fill <= fill + 6'd1;
          if (ctrl.start) begin
            state  <= S_COMP;
            resume <= S_ZERO;
          end else begin
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (fill == LEN_START) begin
            state <= S_LEN;
          end else begin
            fill <= fill + 6'd1;
            if (ctrl.start) begin
              state  <= S_COMP;
              resume <= S_ZERO;
            end
          end
        end
        S_LEN: begin
          fill <= fill + 6'd1;
          if (ctrl.start) begin
            state  <= S_COMP;
            resume <= S_OUT;
          end
        end
        S_COMP: begin
          if (core_stat.done) state <= resume;
        end
        S_OUT: begin
          // advance one digest word per transfer
          if (!out_stall) begin
            idx <= idx + 3'd1;
            if (idx == WORD_LAST) begin
              state <= S_IDLE;
              fill  <= '0;
              total <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sha256bsh_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .rd_idx    (idx),
    .stat      (core_stat),
    .hash_word (digest_word)
  );

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign word_index = idx;
  assign last_word  = (idx == WORD_LAST);

`ifndef ASSERT_OFF
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while digest pending");

  a_fresh_after_digest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_word) |=> (!in_stall && fill == '0 && total == '0))
    else $error("hasher not re-initialized after last digest word");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> core_stat.idle)
    else $error("compression started while core busy");

  a_done_in_comp: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> (state == S_COMP))
    else $error("compression finished outside wait state");

  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (word_index == 3'd0))
    else $error("digest does not start at word 0");
`endif

endmodule

FILE: rtl/sha256bsh_core.sv
// SHA-256 compression core: byte-loaded message window, one round per cycle,
// chaining value with final add. Depends on sha256bsh_pkg.
module sha256bsh_core (
  input  logic                     clk,
  input  logic                     rst,
  input  sha256bsh_pkg::core_ctrl_t ctrl,
  input  logic [2:0]               rd_idx,
  output sha256bsh_pkg::core_stat_t stat,
  output logic [31:0]              hash_word
);
  import sha256bsh_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

  cstate_t    state;
  logic [5:0] round;
  word_t      chain [8];
  word_t      wv [8];
  word_t      win [16];

  word_t t1, t2, w_new, ch, maj;

  always_comb begin
    ch    = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj   = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1    = wv[7] + big_sigma1(wv[4]) + ch + ROUND_K[round] + win[0];
    t2    = big_sigma0(wv[0]) + maj;
    // window slot 0 is the word for this round; the tail takes w[t+16]
    w_new = win[0] + small_sigma0(win[1]) + win[9] + small_sigma1(win[14]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      round <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
    end else begin
      case (state)
        C_IDLE: begin
          if (ctrl.start) begin
            state <= C_ROUND;
            round <= '0;
          end else if (ctrl.reinit) begin
            for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
          end
        end
        C_ROUND: begin
          round <= round + 6'd1;
          if (round == ROUND_LAST) state <= C_ADD;
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv[i];
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && ctrl.start) begin
      for (int i = 0; i < 8; i++) wv[i] <= chain[i];
    end else if (state == C_ROUND) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      for (int i = 0; i < 15; i++) win[i] <= {win[i][23:0], win[i+1][31:24]};
      win[15] <= {win[15][23:0], ctrl.byte_in};
    end else if (state == C_ROUND) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_new;
    end
  end

  assign stat.idle = (state == C_IDLE);
  assign stat.done = (state == C_ADD);
  assign hash_word = chain[rd_idx];

endmodule
